/* design/echo_range_min_filter_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the echo range minimum filter.
// ----------------------------------------------------------------------------
`ifndef ECHO_RANGE_MIN_FILTER_UNIT_ASSERT_SVH
`define ECHO_RANGE_MIN_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/erm_pkg.sv */
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types and constants of the echo range minimum filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erm_pkg;

    localparam int STAMP_W          = 32;
    localparam int DIST_W           = 16;
    localparam int MUL_W            = 10;
    localparam int PROD_W           = STAMP_W + MUL_W;
    localparam int CFG_ADDR_W       = 2;
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int DIV_STEPS        = DIST_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0]  MM_PER_METRE     = MUL_W'(1000);
    localparam logic [DIST_W-1:0] MM_MAX           = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] US_PER_METRE_RST = DIST_W'(5882);
    localparam logic [DIST_W-1:0] CAP_MM_RST       = DIST_W'(5000);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_US_PER_METRE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CAP_MM       = CFG_ADDR_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } erm_state_t;

    typedef struct packed {
        logic load_start;
        logic capture;
        logic mul;
        logic div_init;
        logic div_step;
        logic win_write;
        logic scan_read;
    } erm_cmd_t;

    typedef struct packed {
        logic sat;
        logic div_last;
        logic scan_last;
    } erm_status_t;

endpackage

/* design/erm_ctrl.sv */
// ----------------------------------------------------------------------------
// erm_ctrl
// Sequencer that steps one echo edge through capture, scaling, division,
// window update and window scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_echo_level,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  erm_pkg::erm_status_t status,
    output erm_pkg::erm_cmd_t    cmd
);
    import erm_pkg::*;

    erm_state_t state_reg;
    erm_state_t state_next;
    logic       accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !s_echo_level) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_CHECK;
            ST_CHECK: state_next = status.sat ? ST_WRITE : ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_start = accept && s_echo_level;
                cmd.capture    = accept && !s_echo_level;
            end
            ST_MUL:   cmd.mul       = 1'b1;
            ST_CHECK: cmd.div_init  = 1'b1;
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_WRITE: cmd.win_write = 1'b1;
            ST_SCAN:  cmd.scan_read = 1'b1;
            ST_DRAIN: cmd           = '0;
            ST_OUT:   m_valid       = 1'b1;
            default:  cmd           = '0;
        endcase
    end

endmodule

/* design/erm_datapath.sv */
// ----------------------------------------------------------------------------
// erm_datapath
// Configuration registers, pulse width capture, constant scaling, serial
// restoring divider with saturation, distance window memory and min scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erm_datapath #(
    parameter int WINDOW_DEPTH = erm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [erm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [erm_pkg::DIST_W-1:0]        cfg_wdata,
    input  logic [erm_pkg::STAMP_W-1:0]       s_stamp_us,
    input  erm_pkg::erm_cmd_t                 cmd,
    output erm_pkg::erm_status_t              status,
    output logic [erm_pkg::DIST_W-1:0]        raw_mm,
    output logic [erm_pkg::DIST_W-1:0]        min_mm
);
    import erm_pkg::*;

    localparam int                PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Configuration and edge state.
    logic [DIST_W-1:0]    us_per_metre_reg, us_per_metre_next;
    logic [DIST_W-1:0]    cap_mm_reg, cap_mm_next;
    logic [STAMP_W-1:0]   start_stamp_reg, start_stamp_next;

    // Scaling and division.
    logic [STAMP_W-1:0]   width_reg, width_next;
    logic [PROD_W-1:0]    product_reg, product_next;
    logic [DIST_W-1:0]    rem_reg, rem_next;
    logic [DIST_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Window and scan.
    logic [DIST_W-1:0]       win_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    rd_issued_reg;
    logic [DIST_W-1:0]       rd_data_reg;
    logic                    rd_valid_reg;
    logic [DIST_W-1:0]       min_reg, min_next;

    logic [DIST_W:0]         trial;
    logic [DIST_W:0]         trial_diff;
    logic                    trial_ge;
    logic                    sat;
    logic [DIST_W-1:0]       scan_val;

    // The quotient exceeds the output range exactly when the upper part of
    // the dividend already reaches the divisor. A zero divisor lands here too.
    assign sat = product_reg[PROD_W-1:DIST_W] >= (PROD_W - DIST_W)'(us_per_metre_reg);

    assign trial      = {rem_reg, quo_reg[DIST_W-1]};
    assign trial_diff = trial - {1'b0, us_per_metre_reg};
    assign trial_ge   = trial >= {1'b0, us_per_metre_reg};

    // A slot that was never written reads as the full-scale distance.
    assign scan_val = rd_valid_reg ? rd_data_reg : MM_MAX;

    always_comb begin
        us_per_metre_next = us_per_metre_reg;
        cap_mm_next       = cap_mm_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_US_PER_METRE: us_per_metre_next = cfg_wdata;
                REG_CAP_MM:       cap_mm_next       = cfg_wdata;
                default:          us_per_metre_next = us_per_metre_reg;
            endcase
        end
    end

    always_comb begin
        start_stamp_next = start_stamp_reg;
        width_next       = width_reg;
        product_next     = product_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        valid_next       = valid_reg;
        wr_ptr_next      = wr_ptr_reg;
        scan_idx_next    = scan_idx_reg;
        min_next         = min_reg;

        if (cmd.load_start) begin
            start_stamp_next = s_stamp_us;
        end
        if (cmd.capture) begin
            width_next = s_stamp_us - start_stamp_reg;
        end
        if (cmd.mul) begin
            product_next = PROD_W'(width_reg) * PROD_W'(MM_PER_METRE);
        end
        if (cmd.div_init) begin
            rem_next     = product_reg[2*DIST_W-1:DIST_W];
            quo_next     = sat ? MM_MAX : product_reg[DIST_W-1:0];
            div_cnt_next = '0;
        end
        if (cmd.div_step) begin
            rem_next     = trial_ge ? trial_diff[DIST_W-1:0] : trial[DIST_W-1:0];
            quo_next     = {quo_reg[DIST_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (cmd.win_write) begin
            valid_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next            = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            scan_idx_next          = '0;
            min_next               = cap_mm_reg;
        end
        if (cmd.scan_read) begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (rd_issued_reg && (scan_val < min_reg)) begin
            min_next = scan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            us_per_metre_reg <= US_PER_METRE_RST;
            cap_mm_reg       <= CAP_MM_RST;
            start_stamp_reg  <= '0;
            valid_reg        <= '0;
            wr_ptr_reg       <= '0;
            scan_idx_reg     <= '0;
            div_cnt_reg      <= '0;
            rd_issued_reg    <= 1'b0;
        end else begin
            us_per_metre_reg <= us_per_metre_next;
            cap_mm_reg       <= cap_mm_next;
            start_stamp_reg  <= start_stamp_next;
            valid_reg        <= valid_next;
            wr_ptr_reg       <= wr_ptr_next;
            scan_idx_reg     <= scan_idx_next;
            div_cnt_reg      <= div_cnt_next;
            rd_issued_reg    <= cmd.scan_read;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg   <= width_next;
        product_reg <= product_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        min_reg     <= min_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_write) begin
            win_mem[wr_ptr_reg] <= quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_read) begin
            rd_data_reg  <= win_mem[scan_idx_reg];
            rd_valid_reg <= valid_reg[scan_idx_reg];
        end
    end

    assign status.sat       = sat;
    assign status.div_last  = (div_cnt_reg == DIV_LAST);
    assign status.scan_last = (scan_idx_reg == PTR_LAST);

    assign raw_mm = quo_reg;
    assign min_mm = min_reg;

endmodule

/* design/echo_range_min_filter_unit.sv */
// ----------------------------------------------------------------------------
// echo_range_min_filter_unit
// Echo pulse ranging with a sliding-window minimum over recent distances.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one echo edge per transaction: the line level after
//   the edge and its microsecond timestamp. A rising edge only records the
//   timestamp and is done in the cycle it is accepted. A falling edge yields
//   one m_ transaction with the raw distance and the window minimum capped
//   at cap_mm.
//   A falling edge passes through a multiply, a range check, 16 divider
//   steps that are skipped on saturation, a window write, WINDOW_DEPTH
//   reads of the window memory and a final compare before m_valid; the
//   pulse width is captured at the accepting edge. The divider works
//   serially in 16 steps and the window scan reads one slot at a time. One
//   edge is in flight at a time; s_ready is high only while the block is
//   empty, so a new falling edge is taken only after the result of the last
//   one has been taken. If the receiver stalls, the result holds on the m_
//   ports and s_ready stays low until the transaction completes.
//   Reset restores the register defaults, clears the start timestamp and the
//   window pointer, and marks every window slot as invalid, so that it reads as full scale. No clearing
//   pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_range_min_filter_unit #(
    parameter int WINDOW_DEPTH = erm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [erm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [erm_pkg::DIST_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_echo_level,
    input  logic [erm_pkg::STAMP_W-1:0]    s_stamp_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [erm_pkg::DIST_W-1:0]     m_raw_mm,
    output logic [erm_pkg::DIST_W-1:0]     m_min_mm
);
    import erm_pkg::*;

    erm_cmd_t    cmd;
    erm_status_t status;

    erm_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_echo_level (s_echo_level),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .status       (status),
        .cmd          (cmd)
    );

    erm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_stamp_us (s_stamp_us),
        .cmd        (cmd),
        .status     (status),
        .raw_mm     (m_raw_mm),
        .min_mm     (m_min_mm)
    );

endmodule

/* design/erm_checker.sv */
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks of the echo range minimum filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "echo_range_min_filter_unit_assert.svh"

module erm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_echo_level,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [erm_pkg::DIST_W-1:0]  m_raw_mm,
    input logic [erm_pkg::DIST_W-1:0]  m_min_mm
);

    // A rising edge never produces a result.
    `ERM_ASSERT_NEXT(a_rise_no_result, aclk, aresetn, s_valid && s_ready && s_echo_level, !m_valid, "rising edge produced a result")

    // A falling edge occupies the block until its result is taken.
    `ERM_ASSERT_NEXT(a_fall_busy, aclk, aresetn, s_valid && s_ready && !s_echo_level, !s_ready, "block took a new edge during a measurement")

    // Only one edge is in flight, so a pending result blocks the input.
    `ERM_ASSERT_SAME(a_one_in_flight, aclk, aresetn, m_valid, !s_ready, "input open while a result is pending")

    // The newest distance is in the window, so the minimum cannot exceed it.
    `ERM_ASSERT_SAME(a_min_le_raw, aclk, aresetn, m_valid, m_min_mm <= m_raw_mm, "window minimum above raw distance")

    `ERM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_raw_mm) && $stable(m_min_mm), "stalled result changed")

endmodule

bind echo_range_min_filter_unit erm_checker u_erm_checker (.*);
